// ===== rtl/a2b_pkg.sv =====
// Shared constants, codes and the job record for the avcC to Annex B converter.
package a2b_pkg;

    localparam int STORE_BYTES = 256;
    localparam int ADDR_W = $clog2(STORE_BYTES);
    localparam int LEN_W = $clog2(STORE_BYTES + 1);
    localparam int POS_W = $clog2(STORE_BYTES + 6);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    localparam logic [LEN_W-1:0] STORE_MAX = LEN_W'(STORE_BYTES);

    localparam logic [3:0] PH_START   = 4'd0;
    localparam logic [3:0] PH_SKIP1   = 4'd1;
    localparam logic [3:0] PH_SKIP2   = 4'd2;
    localparam logic [3:0] PH_SKIP3   = 4'd3;
    localparam logic [3:0] PH_LENSIZE = 4'd4;
    localparam logic [3:0] PH_NUM_SPS = 4'd5;
    localparam logic [3:0] PH_NUM_PPS = 4'd6;
    localparam logic [3:0] PH_ULEN_HI = 4'd7;
    localparam logic [3:0] PH_ULEN_LO = 4'd8;
    localparam logic [3:0] PH_UNIT    = 4'd9;
    localparam logic [3:0] PH_DONE    = 4'd10;

    localparam logic [1:0] ST_DATA      = 2'd0;
    localparam logic [1:0] ST_HDR_OK    = 2'd1;
    localparam logic [1:0] ST_HDR_BAD   = 2'd2;
    localparam logic [1:0] ST_MALFORMED = 2'd3;

    localparam logic       CMD_HEADER = 1'b0;
    localparam logic [1:0] LEN_CODE_BAD = 2'd2;
    localparam logic [4:0] NAL_IDR = 5'd5;
    localparam logic [4:0] NAL_SLICE = 5'd1;
    localparam logic [2:0] SC_LONG = 3'd4;
    localparam logic [2:0] SC_SHORT = 3'd3;

    typedef struct packed {
        logic [2:0]        wr_count;
        logic [ADDR_W-1:0] wr_addr;
        logic              wr_sc;
        logic [7:0]        wr_byte;
        logic [LEN_W-1:0]  store_len;
        logic [2:0]        sc_len;
        logic              has_data;
        logic [7:0]        data;
        logic [1:0]        status;
        logic              pend;
        logic              need_result;
    } job_t;

endpackage

// ===== rtl/a2b_in_if.sv =====
// Input channel carrying one command byte per beat.
interface a2b_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output command, output data_byte, output last_byte,
                    input ready);
    modport sink (input valid, input command, input data_byte, input last_byte,
                  output ready);
endinterface

// ===== rtl/a2b_out_if.sv =====
// Output channel carrying up to eight converted bytes per beat.
interface a2b_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] out_bytes;
    logic [3:0]  byte_count;
    logic [1:0]  status;
    logic        packet_end;
    logic        last_of_run;

    modport source (output valid, output out_bytes, output byte_count, output status,
                    output packet_end, output last_of_run, input ready);
    modport sink (input valid, input out_bytes, input byte_count, input status,
                  input packet_end, input last_of_run, output ready);
endinterface

// ===== rtl/a2b_front.sv =====
// Front part: parses header and packet bytes and issues jobs to the back part.
module a2b_front
    import a2b_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    a2b_in_if.sink stream,
    output logic  push,
    output job_t  push_job,
    input  logic  can_push
);

    logic [LEN_W-1:0] store_len_reg, store_len_next;
    logic [2:0]       prefix_reg, prefix_next;
    logic             conv_reg, conv_next;
    logic             await_reg, await_next;
    logic [3:0]       phase_reg, phase_next;
    logic [7:0]       units_reg, units_next;
    logic [15:0]      ubl_reg, ubl_next;
    logic             pps_reg, pps_next;
    logic             hfail_reg, hfail_next;
    logic [1:0]       idx_reg, idx_next;
    logic [31:0]      acc_reg, acc_next;
    logic [31:0]      nbl_reg, nbl_next;
    logic             inpay_reg, inpay_next;
    logic             hasout_reg, hasout_next;
    logic             pfail_reg, pfail_next;

    logic             accept;
    logic             fin;
    logic [7:0]       units_dec;
    logic [LEN_W-1:0] room;
    logic [2:0]       idx_inc;
    logic             fail;
    logic             ok;
    logic             do_start;
    job_t             job;
    logic             need_job;

    assign stream.ready = can_push;
    assign accept = stream.valid && can_push;
    assign push = accept && need_job;
    assign push_job = job;

    always_comb
    begin
        store_len_next = store_len_reg;
        prefix_next = prefix_reg;
        conv_next = conv_reg;
        await_next = await_reg;
        phase_next = phase_reg;
        units_next = units_reg;
        ubl_next = ubl_reg;
        pps_next = pps_reg;
        hfail_next = hfail_reg;
        idx_next = idx_reg;
        acc_next = acc_reg;
        nbl_next = nbl_reg;
        inpay_next = inpay_reg;
        hasout_next = hasout_reg;
        pfail_next = pfail_reg;
        fin = 1'b0;
        units_dec = units_reg - 8'd1;
        room = STORE_MAX - store_len_reg;
        idx_inc = {1'b0, idx_reg} + 3'd1;
        fail = 1'b0;
        ok = 1'b0;
        do_start = 1'b0;
        need_job = 1'b0;
        job = '0;
        job.wr_addr = store_len_reg[ADDR_W-1:0];
        job.wr_byte = stream.data_byte;
        job.data = stream.data_byte;

        if (stream.command == CMD_HEADER)
        begin
            if (phase_reg == PH_START)
            begin
                store_len_next = '0;
                hfail_next = 1'b0;
                pps_next = 1'b0;
                phase_next = PH_SKIP1;
            end
            else if (!hfail_reg)
            begin
                unique case (phase_reg)
                    PH_SKIP1, PH_SKIP2, PH_SKIP3:
                    begin
                        phase_next = phase_reg + 4'd1;
                    end
                    PH_LENSIZE:
                    begin
                        if (stream.data_byte[1:0] == LEN_CODE_BAD)
                            hfail_next = 1'b1;
                        else
                            prefix_next = {1'b0, stream.data_byte[1:0]} + 3'd1;
                        phase_next = PH_NUM_SPS;
                    end
                    PH_NUM_SPS:
                    begin
                        units_next = {3'b000, stream.data_byte[4:0]};
                        if (stream.data_byte[4:0] == 5'd0)
                        begin
                            pps_next = 1'b1;
                            phase_next = PH_NUM_PPS;
                        end
                        else
                            phase_next = PH_ULEN_HI;
                    end
                    PH_NUM_PPS:
                    begin
                        pps_next = 1'b1;
                        units_next = stream.data_byte;
                        phase_next = (stream.data_byte == 8'd0) ? PH_DONE : PH_ULEN_HI;
                    end
                    PH_ULEN_HI:
                    begin
                        ubl_next = {stream.data_byte, 8'h00};
                        phase_next = PH_ULEN_LO;
                    end
                    PH_ULEN_LO:
                    begin
                        ubl_next = {ubl_reg[15:8], stream.data_byte};
                        job.wr_sc = 1'b1;
                        if (room < LEN_W'(4))
                        begin
                            hfail_next = 1'b1;
                            job.wr_count = room[2:0];
                        end
                        else
                            job.wr_count = 3'd4;
                        store_len_next = store_len_reg + LEN_W'(job.wr_count);
                        if (ubl_next == 16'd0)
                            fin = 1'b1;
                        else
                            phase_next = PH_UNIT;
                    end
                    PH_UNIT:
                    begin
                        if (store_len_reg == STORE_MAX)
                            hfail_next = 1'b1;
                        else
                        begin
                            job.wr_count = 3'd1;
                            store_len_next = store_len_reg + LEN_W'(1);
                        end
                        ubl_next = ubl_reg - 16'd1;
                        if (ubl_next == 16'd0)
                            fin = 1'b1;
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
                if (fin)
                begin
                    units_next = units_dec;
                    if (units_dec != 8'd0)
                        phase_next = PH_ULEN_HI;
                    else if (!pps_reg)
                    begin
                        pps_next = 1'b1;
                        phase_next = PH_NUM_PPS;
                    end
                    else
                        phase_next = PH_DONE;
                end
            end
            if (stream.last_byte)
            begin
                ok = !hfail_next && (phase_next == PH_DONE);
                conv_next = ok;
                if (ok)
                    await_next = 1'b1;
                phase_next = PH_START;
                job.need_result = 1'b1;
                job.status = ok ? ST_HDR_OK : ST_HDR_BAD;
            end
            need_job = (job.wr_count != 3'd0) || stream.last_byte;
        end
        else if (!conv_reg)
        begin
            job.has_data = 1'b1;
            job.pend = stream.last_byte;
            need_job = 1'b1;
        end
        else if (pfail_reg)
        begin
            job.need_result = 1'b1;
            job.status = ST_MALFORMED;
            job.pend = 1'b1;
            need_job = stream.last_byte;
        end
        else
        begin
            if (!inpay_reg)
            begin
                acc_next = (idx_reg == 2'd0) ? {24'd0, stream.data_byte}
                                             : {acc_reg[23:0], stream.data_byte};
                idx_next = idx_inc[1:0];
                if (idx_inc >= prefix_reg)
                begin
                    idx_next = 2'd0;
                    nbl_next = acc_next;
                    if (acc_next[31])
                    begin
                        fail = 1'b1;
                        pfail_next = 1'b1;
                    end
                    else if (acc_next == 32'd0)
                        do_start = 1'b1;
                    else
                        inpay_next = 1'b1;
                end
            end
            else
            begin
                if (nbl_reg == acc_reg)
                begin
                    if (await_reg && stream.data_byte[4:0] == NAL_IDR)
                    begin
                        job.store_len = store_len_reg;
                        await_next = 1'b0;
                    end
                    else if (!await_reg && stream.data_byte[4:0] == NAL_SLICE)
                        await_next = 1'b1;
                    do_start = 1'b1;
                end
                job.has_data = 1'b1;
                nbl_next = nbl_reg - 32'd1;
                if (nbl_next == 32'd0)
                    inpay_next = 1'b0;
            end
            if (do_start)
            begin
                job.sc_len = hasout_reg ? SC_SHORT : SC_LONG;
                hasout_next = 1'b1;
            end
            if (stream.last_byte && (inpay_next || idx_next != 2'd0))
                fail = 1'b1;
            job.pend = stream.last_byte;
            job.need_result = fail || stream.last_byte;
            job.status = fail ? ST_MALFORMED : ST_DATA;
            need_job = job.need_result || job.has_data || (job.sc_len != 3'd0);
        end

        if (stream.command != CMD_HEADER && stream.last_byte)
        begin
            idx_next = 2'd0;
            acc_next = 32'd0;
            nbl_next = 32'd0;
            inpay_next = 1'b0;
            hasout_next = 1'b0;
            pfail_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_len_reg <= '0;
            prefix_reg <= SC_LONG;
            conv_reg <= 1'b0;
            await_reg <= 1'b0;
            phase_reg <= PH_START;
            units_reg <= 8'd0;
            ubl_reg <= 16'd0;
            pps_reg <= 1'b0;
            hfail_reg <= 1'b0;
            idx_reg <= 2'd0;
            acc_reg <= 32'd0;
            nbl_reg <= 32'd0;
            inpay_reg <= 1'b0;
            hasout_reg <= 1'b0;
            pfail_reg <= 1'b0;
        end
        else if (accept)
        begin
            store_len_reg <= store_len_next;
            prefix_reg <= prefix_next;
            conv_reg <= conv_next;
            await_reg <= await_next;
            phase_reg <= phase_next;
            units_reg <= units_next;
            ubl_reg <= ubl_next;
            pps_reg <= pps_next;
            hfail_reg <= hfail_next;
            idx_reg <= idx_next;
            acc_reg <= acc_next;
            nbl_reg <= nbl_next;
            inpay_reg <= inpay_next;
            hasout_reg <= hasout_next;
            pfail_reg <= pfail_next;
        end
    end

endmodule

// ===== rtl/a2b_queue.sv =====
// Short job queue between the front and back parts.
module a2b_queue
    import a2b_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic can_push,
    input  logic pop,
    output job_t pop_job,
    output logic has_job
);

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg, wptr_next;
    logic [QPTR_W-1:0] rptr_reg, rptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    assign can_push = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign has_job = (count_reg != '0);
    assign pop_job = entry_reg[rptr_reg];

    always_comb
    begin
        wptr_next = push ? wptr_reg + QPTR_W'(1) : wptr_reg;
        rptr_next = pop ? rptr_reg + QPTR_W'(1) : rptr_reg;
        count_next = count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/a2b_back.sv =====
// Back part: writes the parameter-set store and packs output bytes into beats.
module a2b_back
    import a2b_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic has_job,
    input  job_t pop_job,
    output logic pop,
    a2b_out_if.source result
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_WRITE = 3'b010,
        S_EMIT  = 3'b100
    } state_t;

    logic [7:0]       mem [STORE_BYTES];
    logic [7:0]       rd_data_reg;

    state_t           state_reg, state_next;
    job_t             job_reg;
    logic [1:0]       wk_reg, wk_next;
    logic [POS_W-1:0] p_reg, p_next;
    logic [63:0]      acc_word_reg, acc_word_next;
    logic [2:0]       acc_cnt_reg, acc_cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic [63:0]      out_bytes_reg;
    logic [3:0]       out_count_reg;
    logic [1:0]       out_status_reg;
    logic             out_pend_reg;
    logic             out_last_reg;

    logic             load;
    logic [63:0]      load_word;
    logic [3:0]       load_count;
    logic             load_final;
    logic             out_free;
    logic [POS_W-1:0] total;
    logic [POS_W-1:0] q;
    logic [7:0]       cur_byte;
    logic [63:0]      ins_word;
    logic [3:0]       new_cnt;
    logic             seq_last;
    logic             wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]       wr_data;

    assign out_free = !out_valid_reg || result.ready;
    assign pop = (state_reg == S_IDLE) && has_job;

    assign result.valid = out_valid_reg;
    assign result.out_bytes = out_bytes_reg;
    assign result.byte_count = out_count_reg;
    assign result.status = out_status_reg;
    assign result.packet_end = out_pend_reg;
    assign result.last_of_run = out_last_reg;

    always_comb
    begin
        state_next = state_reg;
        wk_next = wk_reg;
        p_next = p_reg;
        acc_word_next = acc_word_reg;
        acc_cnt_next = acc_cnt_reg;
        load = 1'b0;
        load_word = 64'd0;
        load_count = 4'd0;
        load_final = 1'b0;
        wr_en = 1'b0;
        wr_addr = job_reg.wr_addr + ADDR_W'(wk_reg);
        wr_data = job_reg.wr_sc ? ((wk_reg == 2'd3) ? 8'd1 : 8'd0) : job_reg.wr_byte;

        total = POS_W'(job_reg.store_len) + POS_W'(job_reg.sc_len)
              + POS_W'(job_reg.has_data);
        q = p_reg - POS_W'(job_reg.store_len);
        if (p_reg < POS_W'(job_reg.store_len))
            cur_byte = rd_data_reg;
        else if (q < POS_W'(job_reg.sc_len))
            cur_byte = (q == POS_W'(job_reg.sc_len) - POS_W'(1)) ? 8'd1 : 8'd0;
        else
            cur_byte = job_reg.data;
        ins_word = acc_word_reg | ({56'd0, cur_byte} << {~acc_cnt_reg, 3'b000});
        new_cnt = {1'b0, acc_cnt_reg} + 4'd1;
        seq_last = (p_reg + POS_W'(1) == total);

        unique case (state_reg)
            S_IDLE:
            begin
                p_next = '0;
                wk_next = 2'd0;
                acc_word_next = 64'd0;
                acc_cnt_next = 3'd0;
                if (has_job)
                    state_next = (pop_job.wr_count != 3'd0) ? S_WRITE : S_EMIT;
            end
            S_WRITE:
            begin
                wr_en = 1'b1;
                wk_next = wk_reg + 2'd1;
                if ({1'b0, wk_reg} + 3'd1 == job_reg.wr_count)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (p_reg < total)
                begin
                    if (new_cnt == 4'd8 || seq_last)
                    begin
                        if (out_free)
                        begin
                            load = 1'b1;
                            load_word = ins_word;
                            load_count = new_cnt;
                            load_final = seq_last;
                            acc_word_next = 64'd0;
                            acc_cnt_next = 3'd0;
                            p_next = p_reg + POS_W'(1);
                            if (seq_last)
                                state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        acc_word_next = ins_word;
                        acc_cnt_next = new_cnt[2:0];
                        p_next = p_reg + POS_W'(1);
                    end
                end
                else if (job_reg.need_result)
                begin
                    if (out_free)
                    begin
                        load = 1'b1;
                        load_final = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[p_next[ADDR_W-1:0]];
        if (pop)
            job_reg <= pop_job;
        if (load)
        begin
            out_bytes_reg <= load_word;
            out_count_reg <= load_count;
            out_status_reg <= load_final ? job_reg.status : ST_DATA;
            out_pend_reg <= load_final && job_reg.pend;
            out_last_reg <= load_final;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wk_reg <= 2'd0;
            p_reg <= '0;
            acc_word_reg <= 64'd0;
            acc_cnt_reg <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wk_reg <= wk_next;
            p_reg <= p_next;
            acc_word_reg <= acc_word_next;
            acc_cnt_reg <= acc_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/avcc_to_annexb_converter_top.sv =====
// Top level of the avcC to Annex B converter.
// An input beat is taken whenever the four-entry job queue has room.
// The back part pops each job and emits its output bytes (stored parameter sets,
// start code, data) packed into beats, stalling while the output is not taken.
// A header byte that writes the store is written into it one stored byte at a time.
// Reset clears all control state at once; the parameter-set store is not cleared.
module avcc_to_annexb_converter_top
    import a2b_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    a2b_in_if.sink stream,
    a2b_out_if.source result
);

    logic push;
    job_t push_job;
    logic can_push;
    logic pop;
    job_t pop_job;
    logic has_job;

    a2b_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .stream   (stream),
        .push     (push),
        .push_job (push_job),
        .can_push (can_push)
    );

    a2b_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .can_push (can_push),
        .pop      (pop),
        .pop_job  (pop_job),
        .has_job  (has_job)
    );

    a2b_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .has_job (has_job),
        .pop_job (pop_job),
        .pop     (pop),
        .result  (result)
    );

endmodule

// ===== rtl/a2b_checker.sv =====
// Port-level checks on the converter's output beats.
module a2b_checker
    import a2b_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        valid,
    input logic        ready,
    input logic [63:0] out_bytes,
    input logic [3:0]  byte_count,
    input logic [1:0]  status,
    input logic        packet_end,
    input logic        last_of_run
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(out_bytes) && $stable(byte_count))
        else $error("Output beat changed while stalled.");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !last_of_run |-> byte_count == 4'd8)
        else $error("A beat before the last of a run is not full.");

    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        valid && packet_end |-> last_of_run)
        else $error("Packet end on a beat that is not the last of its run.");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        valid && status != ST_DATA |-> last_of_run)
        else $error("Status reported on a beat that is not the last of its run.");

endmodule

bind avcc_to_annexb_converter_top a2b_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .valid       (result.valid),
    .ready       (result.ready),
    .out_bytes   (result.out_bytes),
    .byte_count  (result.byte_count),
    .status      (result.status),
    .packet_end  (result.packet_end),
    .last_of_run (result.last_of_run)
);

// ===== sim/avcc_to_annexb_converter_top_tb.sv =====
// Self-checking testbench for the avcC to Annex B converter with a scoreboard class.
module avcc_to_annexb_converter_top_tb;
    import a2b_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic CMD_PACKET = 1'b1;
    localparam int   EMIT_CAP = STORE_BYTES + 16;
    localparam logic [31:0] LEN_OVERSIZE = 32'h8000_0000;

    typedef struct {
        logic [63:0] out_bytes;
        logic [3:0]  byte_count;
        logic [1:0]  status;
        logic        packet_end;
        logic        last_of_run;
    } beat_t;

    class a2b_scoreboard;
        logic [7:0]  store [STORE_BYTES];
        int          store_len;
        int          prefix_len;
        bit          convert_on;
        bit          await_idr;
        logic [3:0]  phase;
        logic [7:0]  units_left;
        logic [15:0] unit_left;
        bit          pps_done;
        bit          hdr_failed;
        int          len_idx;
        logic [31:0] len_acc;
        logic [31:0] nal_left;
        bit          in_payload;
        bit          has_output;
        bit          pkt_failed;
        logic [7:0]  emitted [$];
        beat_t       expected [$];
        int          errors;

        function new();
            store_len = 0;
            prefix_len = 4;
            convert_on = 0;
            await_idr = 0;
            phase = PH_START;
            units_left = 0;
            unit_left = 0;
            pps_done = 0;
            hdr_failed = 0;
            errors = 0;
            clear_packet();
        endfunction

        function void report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endfunction

        function void clear_packet();
            len_idx = 0;
            len_acc = 0;
            nal_left = 0;
            in_payload = 0;
            has_output = 0;
            pkt_failed = 0;
        endfunction

        function void emit(logic [7:0] b);
            if (emitted.size() < EMIT_CAP)
                emitted.push_back(b);
        endfunction

        function void store_put(logic [7:0] b);
            if (store_len >= STORE_BYTES)
                hdr_failed = 1;
            else
            begin
                store[store_len] = b;
                store_len++;
            end
        endfunction

        function void emit_start_code();
            if (!has_output)
                emit(8'h00);
            emit(8'h00);
            emit(8'h00);
            emit(8'h01);
            has_output = 1;
        endfunction

        function void unit_done();
            units_left = units_left - 8'd1;
            if (units_left != 0)
                phase = PH_ULEN_HI;
            else if (!pps_done)
            begin
                pps_done = 1;
                phase = PH_NUM_PPS;
            end
            else
                phase = PH_DONE;
        endfunction

        function void header_byte(logic [7:0] b);
            if (phase == PH_START)
            begin
                store_len = 0;
                hdr_failed = 0;
                pps_done = 0;
                phase = PH_SKIP1;
                return;
            end
            if (hdr_failed)
                return;
            case (phase)
                PH_SKIP1, PH_SKIP2, PH_SKIP3: phase = phase + 4'd1;
                PH_LENSIZE:
                begin
                    if (b[1:0] == LEN_CODE_BAD)
                        hdr_failed = 1;
                    else
                        prefix_len = int'(b[1:0]) + 1;
                    phase = PH_NUM_SPS;
                end
                PH_NUM_SPS:
                begin
                    units_left = {3'b000, b[4:0]};
                    if (units_left == 0)
                    begin
                        pps_done = 1;
                        phase = PH_NUM_PPS;
                    end
                    else
                        phase = PH_ULEN_HI;
                end
                PH_NUM_PPS:
                begin
                    pps_done = 1;
                    units_left = b;
                    phase = (b == 0) ? PH_DONE : PH_ULEN_HI;
                end
                PH_ULEN_HI:
                begin
                    unit_left = {b, 8'h00};
                    phase = PH_ULEN_LO;
                end
                PH_ULEN_LO:
                begin
                    unit_left[7:0] = b;
                    store_put(8'h00);
                    store_put(8'h00);
                    store_put(8'h00);
                    store_put(8'h01);
                    if (unit_left == 0)
                        unit_done();
                    else
                        phase = PH_UNIT;
                end
                PH_UNIT:
                begin
                    store_put(b);
                    unit_left = unit_left - 16'd1;
                    if (unit_left == 0)
                        unit_done();
                end
                default: ;
            endcase
        endfunction

        function void pack_results(bit fail, bit pend);
            beat_t r;
            int    pos;
            int    first;
            first = expected.size();
            pos = 0;
            while (pos < emitted.size())
            begin
                r = '{default: '0};
                while (r.byte_count < 8 && pos < emitted.size())
                begin
                    r.out_bytes[63 - 8 * r.byte_count -: 8] = emitted[pos];
                    r.byte_count++;
                    pos++;
                end
                expected.push_back(r);
            end
            if (expected.size() == first && (fail || pend))
            begin
                r = '{default: '0};
                expected.push_back(r);
            end
            if (expected.size() > first)
            begin
                if (fail)
                    expected[$].status = ST_MALFORMED;
                expected[$].packet_end = pend;
                expected[$].last_of_run = 1'b1;
            end
        endfunction

        function void note_input(logic cmd, logic [7:0] b, logic last);
            beat_t r;
            bit    fail;
            bit    ok;
            emitted.delete();
            fail = 0;
            if (cmd == CMD_HEADER)
            begin
                header_byte(b);
                if (!last)
                    return;
                ok = !hdr_failed && phase == PH_DONE;
                convert_on = ok;
                if (ok)
                    await_idr = 1;
                phase = PH_START;
                r = '{default: '0};
                r.status = ok ? ST_HDR_OK : ST_HDR_BAD;
                r.last_of_run = 1'b1;
                expected.push_back(r);
                return;
            end
            if (!convert_on)
            begin
                emit(b);
                if (last)
                    clear_packet();
                pack_results(0, last);
                return;
            end
            if (pkt_failed)
            begin
                if (!last)
                    return;
                clear_packet();
                pack_results(1, 1);
                return;
            end
            if (!in_payload)
            begin
                len_acc = (len_idx == 0) ? {24'h0, b} : {len_acc[23:0], b};
                len_idx++;
                if (len_idx >= prefix_len)
                begin
                    len_idx = 0;
                    nal_left = len_acc;
                    if (len_acc[31])
                    begin
                        fail = 1;
                        pkt_failed = 1;
                    end
                    else if (len_acc == 0)
                        emit_start_code();
                    else
                        in_payload = 1;
                end
            end
            else
            begin
                if (nal_left == len_acc)
                begin
                    if (await_idr && b[4:0] == NAL_IDR)
                    begin
                        for (int i = 0; i < store_len; i++)
                            emit(store[i]);
                        await_idr = 0;
                    end
                    else if (!await_idr && b[4:0] == NAL_SLICE)
                        await_idr = 1;
                    emit_start_code();
                end
                emit(b);
                nal_left--;
                if (nal_left == 0)
                    in_payload = 0;
            end
            if (last)
            begin
                if (in_payload || len_idx != 0)
                    fail = 1;
                clear_packet();
                pack_results(fail, 1);
            end
            else
                pack_results(fail, 0);
        endfunction

        function void check_result(beat_t got);
            beat_t want;
            if (expected.size() == 0)
            begin
                report($sformatf("unexpected beat %h/%0d", got.out_bytes, got.byte_count));
                return;
            end
            want = expected.pop_front();
            if (got.out_bytes !== want.out_bytes)
                report($sformatf("out_bytes %h, want %h", got.out_bytes, want.out_bytes));
            if (got.byte_count !== want.byte_count)
                report($sformatf("byte_count %0d, want %0d", got.byte_count, want.byte_count));
            if (got.status !== want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.packet_end !== want.packet_end)
                report($sformatf("packet_end %b, want %b", got.packet_end, want.packet_end));
            if (got.last_of_run !== want.last_of_run)
                report($sformatf("last_of_run %b, want %b", got.last_of_run, want.last_of_run));
        endfunction
    endclass

    logic clk;
    logic rst_n;

    a2b_in_if  stream ();
    a2b_out_if result ();

    avcc_to_annexb_converter_top i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream.sink),
        .result (result.source)
    );

    a2b_scoreboard sb = new();
    int beats_sent = 0;
    int tx_idle_pct = 8;
    int rx_idle_pct = 47;
    int hold_left = 0;
    bit hold_req = 0;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    initial
    begin
        stream.valid = 1'b0;
        stream.command = CMD_HEADER;
        stream.data_byte = 8'h00;
        stream.last_byte = 1'b0;
        result.ready = 1'b0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        beat_t got;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (result.valid && result.ready)
            begin
                got.out_bytes = result.out_bytes;
                got.byte_count = result.byte_count;
                got.status = result.status;
                got.packet_end = result.packet_end;
                got.last_of_run = result.last_of_run;
                sb.check_result(got);
            end
            if (hold_req)
            begin
                hold_req = 0;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result.ready <= 1'b0;
            end
            else
                result.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_beat(logic cmd, logic [7:0] b, logic last);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            stream.valid <= 1'b0;
            @(posedge clk);
        end
        stream.valid <= 1'b1;
        stream.command <= cmd;
        stream.data_byte <= b;
        stream.last_byte <= last;
        forever
        begin
            @(posedge clk);
            if (stream.ready)
                break;
        end
        sb.note_input(cmd, b, last);
        beats_sent++;
        if (beats_sent == 160)
        begin
            tx_idle_pct = 47;
            rx_idle_pct = 8;
        end
        else if (beats_sent == 320)
        begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    endtask

    task automatic send_bytes(logic cmd, logic [7:0] q [$]);
        for (int i = 0; i < q.size(); i++)
            send_beat(cmd, q[i], i == q.size() - 1);
    endtask

    task automatic send_header(logic [1:0] code, int nsps, int npps, int maxlen,
                               bit truncate, int extra);
        logic [7:0] q [$];
        int n;
        for (int i = 0; i < 4; i++)
            q.push_back(8'($urandom));
        q.push_back({6'($urandom), code});
        q.push_back({3'($urandom), 5'(nsps)});
        for (int s = 0; s < 2; s++)
        begin
            if (s == 1)
                q.push_back(8'(npps));
            for (int u = 0; u < (s == 0 ? nsps : npps); u++)
            begin
                n = $urandom_range(maxlen);
                q.push_back(8'(n >> 8));
                q.push_back(8'(n));
                for (int k = 0; k < n; k++)
                    q.push_back(8'($urandom));
            end
        end
        for (int i = 0; i < extra; i++)
            q.push_back(8'($urandom));
        if (truncate)
            q = q[0:$urandom_range(q.size() - 2)];
        send_bytes(CMD_HEADER, q);
    endtask

    task automatic send_packet(int nunits, bit broken);
        logic [7:0]  q [$];
        logic [31:0] len;
        logic [4:0]  kind;
        int          plen;
        plen = sb.prefix_len;
        for (int u = 0; u < nunits; u++)
        begin
            len = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12);
            if (broken && plen == 4 && $urandom_range(1) == 0)
                len = len | LEN_OVERSIZE;
            for (int k = plen - 1; k >= 0; k--)
                q.push_back(len[8 * k +: 8]);
            case ($urandom_range(3))
                0: kind = NAL_IDR;
                1: kind = NAL_SLICE;
                default: kind = 5'($urandom);
            endcase
            for (int k = 0; k < len[15:0] && !len[31]; k++)
                q.push_back(k == 0 ? {3'($urandom), kind} : 8'($urandom));
        end
        if (broken && q.size() > 1)
            q = q[0:$urandom_range(q.size() - 1)];
        send_bytes(CMD_PACKET, q);
    endtask

    initial
    begin
        logic [7:0] q [$];
        int r;
        @(posedge rst_n);
        @(posedge clk);
        send_header(2'd3, 1, 1, 6, 0, 0);
        send_packet(2, 0);
        send_packet(3, 0);
        q = '{8'h00, 8'h00, 8'h00, 8'h00};
        send_bytes(CMD_PACKET, q);
        q = '{8'hff, 8'hff, 8'hff, 8'hff, 8'h12, 8'h34};
        send_bytes(CMD_PACKET, q);
        q = '{8'h00, 8'h00, 8'h00, 8'h05, 8'h65, 8'h00};
        send_bytes(CMD_PACKET, q);
        q = '{8'h00, 8'h00};
        send_bytes(CMD_PACKET, q);
        send_header(2'd2, 1, 1, 4, 0, 0);
        q = '{8'h00, 8'hff, 8'h5a};
        send_bytes(CMD_PACKET, q);
        q = '{8'h7e};
        send_bytes(CMD_HEADER, q);
        send_header(2'd0, 0, 0, 0, 0, 2);
        send_packet(2, 0);
        send_header(2'd1, 5, 0, 60, 0, 0);
        send_header(2'd1, 2, 2, 8, 1, 0);
        send_header(2'd1, 2, 1, 8, 0, 0);
        hold_req = 1;
        for (int i = 0; i < 6; i++)
            send_packet(3, 0);
        while (beats_sent < 460)
        begin
            r = $urandom_range(99);
            if (r < 5)
                send_header($urandom_range(1) ? 2'd3 : 2'($urandom), $urandom_range(3),
                            $urandom_range(3), 10, $urandom_range(5) == 0, $urandom_range(1));
            else if (r < 10)
                send_beat(CMD_PACKET, 8'($urandom), 1'($urandom));
            else
                send_packet($urandom_range(1, 3), $urandom_range(9) == 0);
        end
        stream.valid <= 1'b0;
        while (sb.expected.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);
        if (sb.expected.size() != 0)
            sb.report($sformatf("%0d beats never arrived", sb.expected.size()));
        if (sb.errors == 0)
            $display("avcc_to_annexb_converter_top_tb: clean");
        else
            $display("avcc_to_annexb_converter_top_tb: errors");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("avcc_to_annexb_converter_top_tb: errors");
        $finish;
    end

endmodule
